@@ rtl/sha256_hash_engine_top_assert.svh @@
// assertion macros for the sha-256 engine checker
// no dependencies; included by the checker file
`ifndef SHA256_HASH_ENGINE_TOP_ASSERT_SVH
`define SHA256_HASH_ENGINE_TOP_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define SHA_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sha256 engine check failed");

// next-cycle implication, disabled while reset is low
`define SHA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sha256 engine check failed");

`endif

@@ rtl/sha_pkg.sv @@
// shared types, constants and round functions for the sha-256 engine
// no dependencies
package sha_pkg;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_LOAD0,
        S_LOAD1,
        S_ROUND,
        S_UPDATE,
        S_DONE
    } t_state;

    // controls from the controller to the round datapath
    typedef struct packed {
        logic       init_vars;
        logic       round_en;
        logic [5:0] round_idx;
        logic       update;
        logic       finish;
    } t_core_ctl;

    // controls from the controller to the schedule window
    typedef struct packed {
        logic shift;
        logic sel_mem;
    } t_sched_ctl;

    localparam logic [31:0] PadWord = 32'h8000_0000;
    localparam logic [7:0]  PadByte = 8'h80;

    localparam logic [31:0] InitHash [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] RoundK [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // upper-case sigma 0: rotations by 2, 13, 22
    function automatic logic [31:0] big_sig0(logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    // upper-case sigma 1: rotations by 6, 11, 25
    function automatic logic [31:0] big_sig1(logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    // lower-case sigma 0: rotations by 7, 18, shift by 3
    function automatic logic [31:0] small_sig0(logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    // lower-case sigma 1: rotations by 17, 19, shift by 10
    function automatic logic [31:0] small_sig1(logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

endpackage

@@ rtl/sha_blk_mem.sv @@
// 16 x 32 block word memory, one write port, one registered read port
// no dependencies
module sha_blk_mem (
    input  logic        i_clk,
    input  logic        i_wr_en,
    input  logic [3:0]  i_wr_addr,
    input  logic [31:0] i_wr_data,
    input  logic [3:0]  i_rd_addr,
    output logic [31:0] o_rd_data
);

    logic [31:0] r_mem [16];
    logic [31:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port, registered
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/sha_sched.sv @@
// message schedule: 16-word sliding window and expansion of later words
// depends on sha_pkg
module sha_sched (
    input  logic                  i_clk,
    input  sha_pkg::t_sched_ctl   i_ctl,
    input  logic [31:0]           i_mem_data,
    output logic [31:0]           o_w_cur
);

    logic [31:0] r_win [16];
    logic [31:0] w_calc;
    logic [31:0] w_in;

    // next schedule word from the window (window holds w[t-15] .. w[t])
    assign w_calc = sha_pkg::small_sig1(r_win[14]) + r_win[9]
                  + sha_pkg::small_sig0(r_win[1]) + r_win[0];
    assign w_in   = i_ctl.sel_mem ? i_mem_data : w_calc;

    // window shift
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            for (int j = 0; j < 15; j++) begin
                r_win[j] <= r_win[j+1];
            end
            r_win[15] <= w_in;
        end
    end

    assign o_w_cur = r_win[15];

endmodule

@@ rtl/sha_core.sv @@
// round datapath: chaining value, working variables and digest output buffer
// depends on sha_pkg
module sha_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sha_pkg::t_core_ctl  i_ctl,
    input  logic [31:0]         i_w,
    input  logic                i_out_ready,
    output logic                o_dig_busy,
    output logic [31:0]         o_digest_word,
    output logic [2:0]          o_word_index,
    output logic                o_last_word
);

    logic [31:0] r_chain [8];
    logic [31:0] r_v [8];
    logic [31:0] r_dig [8];
    logic        r_dig_busy;
    logic [2:0]  r_dig_idx;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] ch;
    logic [31:0] maj;
    logic        dig_take;

    // one compression round
    assign ch  = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
    assign maj = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
    assign t1  = r_v[7] + sha_pkg::big_sig1(r_v[4]) + ch
               + sha_pkg::RoundK[i_ctl.round_idx] + i_w;
    assign t2  = sha_pkg::big_sig0(r_v[0]) + maj;

    assign dig_take = r_dig_busy && i_out_ready;

    // chaining value and output buffer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < 8; j++) begin
                r_chain[j] <= sha_pkg::InitHash[j];
            end
            r_dig_busy <= 1'b0;
            r_dig_idx  <= '0;
        end else begin
            if (i_ctl.update) begin
                for (int j = 0; j < 8; j++) begin
                    r_chain[j] <= r_chain[j] + r_v[j];
                end
            end else if (i_ctl.finish) begin
                for (int j = 0; j < 8; j++) begin
                    r_chain[j] <= sha_pkg::InitHash[j];
                end
            end
            if (i_ctl.finish) begin
                r_dig_busy <= 1'b1;
                r_dig_idx  <= '0;
            end else if (dig_take) begin
                r_dig_idx <= r_dig_idx + 3'd1;
                if (r_dig_idx == 3'd7) begin
                    r_dig_busy <= 1'b0;
                end
            end
        end
    end

    // working variables and digest shift register
    always_ff @(posedge i_clk) begin
        if (i_ctl.init_vars) begin
            for (int j = 0; j < 8; j++) begin
                r_v[j] <= r_chain[j];
            end
        end else if (i_ctl.round_en) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end
        if (i_ctl.finish) begin
            for (int j = 0; j < 8; j++) begin
                r_dig[j] <= r_chain[j];
            end
        end else if (dig_take) begin
            for (int j = 0; j < 7; j++) begin
                r_dig[j] <= r_dig[j+1];
            end
        end
    end

    assign o_dig_busy    = r_dig_busy;
    assign o_digest_word = r_dig[0];
    assign o_word_index  = r_dig_idx;
    assign o_last_word   = (r_dig_idx == 3'd7);

endmodule

@@ rtl/sha_ctrl.sv @@
// controller: word intake, byte count, padding, memory addressing, round sequencing
// depends on sha_pkg
module sha_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [31:0]           i_message_word,
    input  logic [2:0]            i_valid_bytes,
    input  logic                  i_final_item,
    input  logic                  i_dig_busy,
    output logic                  o_ready,
    output logic                  o_wr_en,
    output logic [3:0]            o_wr_addr,
    output logic [31:0]           o_wr_data,
    output logic [3:0]            o_rd_addr,
    output sha_pkg::t_core_ctl    o_core_ctl,
    output sha_pkg::t_sched_ctl   o_sched_ctl
);

    sha_pkg::t_state r_state, n_state;
    logic [63:0] r_cnt, n_cnt;
    logic [3:0]  r_pidx, n_pidx;
    logic [5:0]  r_round, n_round;
    logic        r_need80, n_need80;
    logic        r_tail_ok, n_tail_ok;
    logic        r_msg_end, n_msg_end;
    logic        r_padding, n_padding;

    logic [3:0]  wi;
    logic [2:0]  nv;
    logic [31:0] fin_word;
    logic [63:0] bit_len;
    logic [31:0] pad_data;
    logic        accept;

    // keep the valid leading bytes, place the pad byte right after them
    function automatic logic [31:0] f_final_word(logic [31:0] w, logic [2:0] n);
        logic [31:0] r;
        r = '0;
        for (int b = 0; b < 4; b++) begin
            if (3'(b) < n) begin
                r[31-8*b -: 8] = w[31-8*b -: 8];
            end else if (3'(b) == n) begin
                r[31-8*b -: 8] = sha_pkg::PadByte;
            end
        end
        return r;
    endfunction

    assign wi       = r_cnt[5:2];
    assign nv       = (i_valid_bytes > 3'd4) ? 3'd4 : i_valid_bytes;
    assign fin_word = f_final_word(i_message_word, nv);
    assign bit_len  = {r_cnt[60:0], 3'b000};
    assign o_ready  = (r_state == sha_pkg::S_IDLE);
    assign accept   = i_valid && o_ready;

    // padding word for the current pad position
    always_comb begin
        if (r_need80) begin
            pad_data = sha_pkg::PadWord;
        end else if (r_tail_ok && (r_pidx == 4'd14)) begin
            pad_data = bit_len[63:32];
        end else if (r_tail_ok && (r_pidx == 4'd15)) begin
            pad_data = bit_len[31:0];
        end else begin
            pad_data = '0;
        end
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= sha_pkg::S_IDLE;
            r_cnt     <= '0;
            r_pidx    <= '0;
            r_round   <= '0;
            r_need80  <= 1'b0;
            r_tail_ok <= 1'b0;
            r_msg_end <= 1'b0;
            r_padding <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_pidx    <= n_pidx;
            r_round   <= n_round;
            r_need80  <= n_need80;
            r_tail_ok <= n_tail_ok;
            r_msg_end <= n_msg_end;
            r_padding <= n_padding;
        end
    end

    // next state and outputs
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_pidx      = r_pidx;
        n_round     = r_round;
        n_need80    = r_need80;
        n_tail_ok   = r_tail_ok;
        n_msg_end   = r_msg_end;
        n_padding   = r_padding;
        o_wr_en     = 1'b0;
        o_wr_addr   = wi;
        o_wr_data   = i_message_word;
        o_rd_addr   = '0;
        o_core_ctl  = '0;
        o_sched_ctl = '0;
        o_core_ctl.round_idx = r_round;

        case (r_state)
            sha_pkg::S_IDLE: begin
                if (accept) begin
                    o_wr_en   = 1'b1;
                    o_wr_addr = wi;
                    n_msg_end = 1'b0;
                    if (!i_final_item) begin
                        o_wr_data = i_message_word;
                        n_cnt     = r_cnt + 64'd4;
                        n_padding = 1'b0;
                        if (wi == 4'd15) begin
                            n_state = sha_pkg::S_LOAD0;
                        end
                    end else begin
                        o_wr_data = fin_word;
                        n_cnt     = r_cnt + {61'b0, nv};
                        n_padding = 1'b1;
                        n_need80  = (nv == 3'd4);
                        n_tail_ok = (nv != 3'd4) && (wi <= 4'd13);
                        n_pidx    = wi + 4'd1;
                        if (wi == 4'd15) begin
                            n_state = sha_pkg::S_LOAD0;
                        end else begin
                            n_state = sha_pkg::S_PAD;
                        end
                    end
                end
            end
            sha_pkg::S_PAD: begin
                o_wr_en   = 1'b1;
                o_wr_addr = r_pidx;
                o_wr_data = pad_data;
                if (r_need80) begin
                    n_need80  = 1'b0;
                    n_tail_ok = (r_pidx <= 4'd13);
                end
                if (r_pidx == 4'd15) begin
                    n_msg_end = !r_need80 && r_tail_ok;
                    n_state   = sha_pkg::S_LOAD0;
                end else begin
                    n_pidx = r_pidx + 4'd1;
                end
            end
            sha_pkg::S_LOAD0: begin
                o_rd_addr = 4'd0;
                n_state   = sha_pkg::S_LOAD1;
            end
            sha_pkg::S_LOAD1: begin
                o_rd_addr            = 4'd1;
                o_sched_ctl.shift    = 1'b1;
                o_sched_ctl.sel_mem  = 1'b1;
                o_core_ctl.init_vars = 1'b1;
                n_round              = '0;
                n_state              = sha_pkg::S_ROUND;
            end
            sha_pkg::S_ROUND: begin
                // memory runs two words ahead of the round in use
                o_rd_addr           = r_round[3:0] + 4'd2;
                o_core_ctl.round_en = 1'b1;
                o_sched_ctl.shift   = 1'b1;
                o_sched_ctl.sel_mem = (r_round < 6'd15);
                n_round             = r_round + 6'd1;
                if (r_round == 6'd63) begin
                    n_state = sha_pkg::S_UPDATE;
                end
            end
            sha_pkg::S_UPDATE: begin
                o_core_ctl.update = 1'b1;
                if (r_msg_end) begin
                    n_state = sha_pkg::S_DONE;
                end else if (r_padding) begin
                    n_pidx    = '0;
                    n_tail_ok = 1'b1;
                    n_state   = sha_pkg::S_PAD;
                end else begin
                    n_state = sha_pkg::S_IDLE;
                end
            end
            sha_pkg::S_DONE: begin
                // wait for the previous digest to drain, then restart the chain
                if (!i_dig_busy) begin
                    o_core_ctl.finish = 1'b1;
                    n_cnt             = '0;
                    n_padding         = 1'b0;
                    n_msg_end         = 1'b0;
                    n_state           = sha_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = sha_pkg::S_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/sha256_hash_engine_top.sv @@
// Timing: a non-final word is taken while o_ready is high; the 16th word of a block starts a
// compression (loads in S_LOAD0 and S_LOAD1, the rounds in S_ROUND, the chain update in S_UPDATE).
// A final word adds padding and one or two compressions; the eight digest words then
// leave one per cycle while i_ready is high. No new words are taken while a block is
// padded or compressed, as o_ready is high only in the idle state.
// Reset (synchronous, active low) loads the initial hash and clears the byte count.
module sha256_hash_engine_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_message_word,
    input  logic [2:0]  i_valid_bytes,
    input  logic        i_final_item,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);

    sha_pkg::t_core_ctl  core_ctl;
    sha_pkg::t_sched_ctl sched_ctl;
    logic        wr_en;
    logic [3:0]  wr_addr;
    logic [31:0] wr_data;
    logic [3:0]  rd_addr;
    logic [31:0] rd_data;
    logic [31:0] w_cur;
    logic        dig_busy;

    // controller
    sha_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .i_message_word (i_message_word),
        .i_valid_bytes  (i_valid_bytes),
        .i_final_item   (i_final_item),
        .i_dig_busy     (dig_busy),
        .o_ready        (o_ready),
        .o_wr_en        (wr_en),
        .o_wr_addr      (wr_addr),
        .o_wr_data      (wr_data),
        .o_rd_addr      (rd_addr),
        .o_core_ctl     (core_ctl),
        .o_sched_ctl    (sched_ctl)
    );

    // block word memory
    sha_blk_mem u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // message schedule
    sha_sched u_sched (
        .i_clk      (i_clk),
        .i_ctl      (sched_ctl),
        .i_mem_data (rd_data),
        .o_w_cur    (w_cur)
    );

    // rounds, chaining value and digest buffer
    sha_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (core_ctl),
        .i_w           (w_cur),
        .i_out_ready   (i_ready),
        .o_dig_busy    (dig_busy),
        .o_digest_word (o_digest_word),
        .o_word_index  (o_word_index),
        .o_last_word   (o_last_word)
    );

    assign o_valid = dig_busy;

endmodule

@@ rtl/sha_chk.sv @@
// port-level checker for the sha-256 engine, bound to the top level
// depends on sha256_hash_engine_top_assert.svh and sha256_hash_engine_top
`include "sha256_hash_engine_top_assert.svh"

module sha_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        i_final_item,
    input logic        o_valid,
    input logic        i_ready,
    input logic [31:0] o_digest_word,
    input logic [2:0]  o_word_index,
    input logic        o_last_word
);

    // last flag marks exactly the eighth word
    `SHA_ASSERT_SAME(a_last_flag, i_clk, i_rst_n, o_valid, o_last_word == (o_word_index == 3'd7))

    // stalled word holds
    `SHA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_digest_word) && $stable(o_word_index))

    // digest words come in order without gaps
    `SHA_ASSERT_NEXT(a_idx_step, i_clk, i_rst_n, o_valid && i_ready && !o_last_word, o_valid && (o_word_index == 3'($past(o_word_index) + 3'd1)))

    // a burst of eight words is never interrupted
    `SHA_ASSERT_NEXT(a_burst, i_clk, i_rst_n, o_valid && !o_last_word, o_valid)

    // a final word starts padding or a compression, so intake pauses
    `SHA_ASSERT_NEXT(a_final_busy, i_clk, i_rst_n, i_valid && o_ready && i_final_item, !o_ready)

endmodule

bind sha256_hash_engine_top sha_chk u_sha_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_ready       (o_ready),
    .i_final_item  (i_final_item),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_digest_word (o_digest_word),
    .o_word_index  (o_word_index),
    .o_last_word   (o_last_word)
);
